// File: hw/rtl/signed_speed_to_step_pulse_generator_top_assert.svh
// assertion macros shared by the step rate generator modules
`ifndef SIGNED_SPEED_TO_STEP_PULSE_GENERATOR_TOP_ASSERT_SVH
`define SIGNED_SPEED_TO_STEP_PULSE_GENERATOR_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SSSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sssp check failed: same cycle implication");

// consequent must hold in the cycle after the antecedent
`define SSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sssp check failed: next cycle implication");

`endif

// File: hw/rtl/sssp_pkg.sv
// shared constants, types and register codes of the step rate generator
package sssp_pkg;

    // field widths
    localparam int FS_W     = 17;
    localparam int RATE_W   = 16;
    localparam int CMD_W    = 18;
    localparam int PERIOD_W = 20;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // arithmetic widths
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 20;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int PROD_W   = FS_W + RATE_W;
    localparam int DIV_N_W  = MUL_P_W + 1;
    localparam int DIV_STEPS = PERIOD_W;
    localparam int DSH_W    = PROD_W + DIV_STEPS - 1;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    // constants
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD  = 20'd1000000;
    localparam logic [MUL_B_W-1:0]  US_PER_S     = 20'd1000000;
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 20'd1000;
    localparam logic [PERIOD_W-1:0] CNT_MAX      = '1;
    localparam logic [FS_W-1:0]     FS_RESET     = 17'd65280;
    localparam logic [RATE_W-1:0]   RATE_RESET   = 16'd8000;

    // register indexes
    typedef enum logic [0:0] {
        REG_FULL_SCALE    = 1'b0,
        REG_MAX_STEP_RATE = 1'b1
    } reg_idx_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [FS_W-1:0]   full_scale;
        logic [RATE_W-1:0] max_step_rate;
    } cfg_t;

    // control from the top level to the period unit
    typedef struct packed {
        logic            start;
        logic            ack;
        logic [FS_W-1:0] mag;
    } unit_req_t;

    // status from the period unit
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [PERIOD_W-1:0] period;
    } unit_rsp_t;

endpackage

// File: hw/rtl/sssp_if.sv
// request and result channel interfaces of the step rate generator
interface sssp_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [sssp_pkg::CMD_W-1:0] command;

    modport source (output valid, output op, output command, input ready);
    modport sink (input valid, input op, input command, output ready);
endinterface

interface sssp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          step;
    logic                          dir_first;
    logic                          dir_second;
    logic [sssp_pkg::PERIOD_W-1:0] period_us;

    modport source (output valid, output step, output dir_first, output dir_second,
                    output period_us, input ready);
    modport sink (input valid, input step, input dir_first, input dir_second,
                  input period_us, output ready);
endinterface

// File: hw/rtl/sssp_cfg_regs.sv
// apb configuration registers: full scale and maximum step rate
module sssp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sssp_pkg::ADDR_W-1:0]   paddr,
    input  logic [sssp_pkg::DATA_W-1:0]   pwdata,
    output logic [sssp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sssp_pkg::cfg_t                cfg
);

    sssp_pkg::cfg_t     cfg_reg;
    sssp_pkg::cfg_t     cfg_next;
    sssp_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    // word address decode
    assign reg_idx = sssp_pkg::reg_idx_t'(paddr[sssp_pkg::ADDR_W-1]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                sssp_pkg::REG_FULL_SCALE:
                    cfg_next.full_scale = pwdata[sssp_pkg::FS_W-1:0];
                sssp_pkg::REG_MAX_STEP_RATE:
                    cfg_next.max_step_rate = pwdata[sssp_pkg::RATE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            sssp_pkg::REG_FULL_SCALE:
                prdata = sssp_pkg::DATA_W'(cfg_reg.full_scale);
            sssp_pkg::REG_MAX_STEP_RATE:
                prdata = sssp_pkg::DATA_W'(cfg_reg.max_step_rate);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale    <= sssp_pkg::FS_RESET;
            cfg_reg.max_step_rate <= sssp_pkg::RATE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/sssp_period_unit.sv
// step period unit: one shared multiplier and a restoring divider under a sequencer
`include "signed_speed_to_step_pulse_generator_top_assert.svh"

module sssp_period_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  sssp_pkg::cfg_t      cfg,
    input  sssp_pkg::unit_req_t req,
    output sssp_pkg::unit_rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_PROD,
        S_MUL_NUM,
        S_CHECK,
        S_DIVIDE,
        S_LOAD,
        S_DONE
    } state_t;

    state_t                           state_reg,  state_next;
    logic [sssp_pkg::FS_W-1:0]        mag_reg,    mag_next;
    logic [sssp_pkg::PROD_W-1:0]      prod_reg,   prod_next;
    logic [sssp_pkg::DIV_N_W-1:0]     rem_reg,    rem_next;
    logic [sssp_pkg::DSH_W-1:0]       dsh_reg,    dsh_next;
    logic [sssp_pkg::PERIOD_W-1:0]    quot_reg,   quot_next;
    logic [sssp_pkg::CNT_W-1:0]       cnt_reg,    cnt_next;
    logic [sssp_pkg::PERIOD_W-1:0]    period_reg, period_next;

    logic [sssp_pkg::MUL_A_W-1:0]     mul_a;
    logic [sssp_pkg::MUL_B_W-1:0]     mul_b;
    logic [sssp_pkg::MUL_P_W-1:0]     mul_p;
    logic                             div_ge;

    // shared multiplier: magnitude times rate, then full scale times one million
    always_comb
    begin
        if (state_reg == S_MUL_NUM)
        begin
            mul_a = cfg.full_scale;
            mul_b = sssp_pkg::US_PER_S;
        end
        else
        begin
            mul_a = mag_reg;
            mul_b = sssp_pkg::MUL_B_W'(cfg.max_step_rate);
        end
    end

    assign mul_p = sssp_pkg::MUL_P_W'(mul_a) * sssp_pkg::MUL_P_W'(mul_b);

    // trial subtract of the divider
    assign div_ge = (sssp_pkg::DSH_W'(rem_reg) >= dsh_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        period_next = period_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    mag_next   = req.mag;
                    state_next = S_MUL_PROD;
                end
            end
            S_MUL_PROD:
            begin
                prod_next  = mul_p[sssp_pkg::PROD_W-1:0];
                state_next = S_MUL_NUM;
            end
            S_MUL_NUM:
            begin
                rem_next   = sssp_pkg::DIV_N_W'(mul_p);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // below one step per second, or no rate at all
                if ((prod_reg == '0) ||
                    (prod_reg < sssp_pkg::PROD_W'(cfg.full_scale)))
                begin
                    period_next = sssp_pkg::SLOW_PERIOD;
                    state_next  = S_DONE;
                end
                else
                begin
                    // bias the numerator so the quotient rounds up
                    rem_next   = rem_reg + sssp_pkg::DIV_N_W'(prod_reg)
                                 - sssp_pkg::DIV_N_W'(1);
                    dsh_next   = {prod_reg, {(sssp_pkg::DIV_STEPS-1){1'b0}}};
                    quot_next  = '0;
                    cnt_next   = sssp_pkg::CNT_W'(sssp_pkg::DIV_STEPS - 1);
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg[sssp_pkg::DIV_N_W-1:0];
                end
                quot_next = {quot_reg[sssp_pkg::PERIOD_W-2:0], div_ge};
                dsh_next  = dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg - sssp_pkg::CNT_W'(1);
                end
            end
            S_LOAD:
            begin
                period_next = (quot_reg > sssp_pkg::SLOW_PERIOD) ?
                              sssp_pkg::SLOW_PERIOD : quot_reg;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (req.ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mag_reg    <= '0;
            prod_reg   <= '0;
            rem_reg    <= '0;
            dsh_reg    <= '0;
            quot_reg   <= '0;
            cnt_reg    <= '0;
            period_reg <= sssp_pkg::SLOW_PERIOD;
        end
        else
        begin
            state_reg  <= state_next;
            mag_reg    <= mag_next;
            prod_reg   <= prod_next;
            rem_reg    <= rem_next;
            dsh_reg    <= dsh_next;
            quot_reg   <= quot_next;
            cnt_reg    <= cnt_next;
            period_reg <= period_next;
        end
    end

    assign rsp.busy   = (state_reg != S_IDLE);
    assign rsp.done   = (state_reg == S_DONE);
    assign rsp.period = period_reg;

    // checks
    `SSSP_ASSERT_SAME(a_start_when_idle, clk, rst_n, req.start, state_reg == S_IDLE)
    `SSSP_ASSERT_SAME(a_period_range, clk, rst_n, rsp.done, (period_reg != '0) && (period_reg <= sssp_pkg::SLOW_PERIOD))
    `SSSP_ASSERT_NEXT(a_divide_ends, clk, rst_n, (state_reg == S_DIVIDE) && (cnt_reg == '0), state_reg == S_LOAD)

endmodule

// File: hw/rtl/signed_speed_to_step_pulse_generator_top.sv
// top level of the signed speed to step pulse generator
//
//   channel   kind          direction  carries
//   in_ch     valid/ready   in         op, command
//   out_ch    valid/ready   out        step, dir_first, dir_second, period_us
//   apb       psel/penable  in         full_scale (0x0), max_step_rate (0x4)
//
// a tick request's result is registered at the accepting edge
// a command request goes through the period unit (two multiplies, a check and a
// 20-step divide); the divide is skipped when the rate is below one step per second
// the period unit serves one command at a time
// a result waits in the output register; a new request is taken once it is gone or leaving
// reset: elapsed 0, period 1000 us, forward, full scale 65280, rate 8000
`include "signed_speed_to_step_pulse_generator_top_assert.svh"

module signed_speed_to_step_pulse_generator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    sssp_in_if.sink                     in_ch,
    sssp_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sssp_pkg::ADDR_W-1:0] paddr,
    input  logic [sssp_pkg::DATA_W-1:0] pwdata,
    output logic [sssp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    typedef enum logic [0:0] {
        T_IDLE,
        T_WAIT
    } state_t;

    state_t                        state_reg,       state_next;
    logic [sssp_pkg::PERIOD_W-1:0] elapsed_reg,     elapsed_next;
    logic [sssp_pkg::PERIOD_W-1:0] step_period_reg, step_period_next;
    logic                          direction_reg,   direction_next;
    logic                          out_valid_reg,   out_valid_next;
    logic                          out_step_reg,    out_step_next;
    logic                          out_dir_reg,     out_dir_next;
    logic [sssp_pkg::PERIOD_W-1:0] out_period_reg,  out_period_next;

    sssp_pkg::cfg_t                cfg;
    sssp_pkg::unit_req_t           unit_req;
    sssp_pkg::unit_rsp_t           unit_rsp;

    logic                          out_free;
    logic                          in_acc;
    logic [sssp_pkg::PERIOD_W-1:0] elapsed_inc;
    logic                          tick_step;
    logic [sssp_pkg::CMD_W-1:0]    cmd_bits;
    logic [sssp_pkg::CMD_W-1:0]    mag_abs;
    logic [sssp_pkg::FS_W-1:0]     mag_clamp;
    logic                          cmd_fwd;

    // configuration registers
    sssp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // period computation
    sssp_period_unit u_period_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (unit_req),
        .rsp   (unit_rsp)
    );

    // handshake
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == T_IDLE) && out_free;
    assign in_acc      = in_ch.valid && in_ch.ready;

    // tick: saturating elapsed count against the current period
    assign elapsed_inc = (elapsed_reg != sssp_pkg::CNT_MAX) ?
                         elapsed_reg + sssp_pkg::PERIOD_W'(1) : elapsed_reg;
    assign tick_step   = (elapsed_inc >= step_period_reg);

    // command: magnitude, clamp and direction
    assign cmd_bits  = in_ch.command;
    assign mag_abs   = cmd_bits[sssp_pkg::CMD_W-1] ?
                       (~cmd_bits + sssp_pkg::CMD_W'(1)) : cmd_bits;
    assign mag_clamp = (mag_abs > sssp_pkg::CMD_W'(cfg.full_scale)) ?
                       cfg.full_scale : mag_abs[sssp_pkg::FS_W-1:0];
    assign cmd_fwd   = !cmd_bits[sssp_pkg::CMD_W-1] && (cmd_bits != '0);

    assign unit_req.start = in_acc && in_ch.op;
    assign unit_req.mag   = mag_clamp;
    assign unit_req.ack   = (state_reg == T_WAIT) && unit_rsp.done && out_free;

    // request handling and result register
    always_comb
    begin
        state_next       = state_reg;
        elapsed_next     = elapsed_reg;
        step_period_next = step_period_reg;
        direction_next   = direction_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_step_next    = out_step_reg;
        out_dir_next     = out_dir_reg;
        out_period_next  = out_period_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.op)
                    begin
                        direction_next = cmd_fwd;
                        state_next     = T_WAIT;
                    end
                    else
                    begin
                        elapsed_next    = tick_step ? '0 : elapsed_inc;
                        out_valid_next  = 1'b1;
                        out_step_next   = tick_step;
                        out_dir_next    = direction_reg;
                        out_period_next = step_period_reg;
                    end
                end
            end
            T_WAIT:
            begin
                if (unit_req.ack)
                begin
                    step_period_next = unit_rsp.period;
                    out_valid_next   = 1'b1;
                    out_step_next    = 1'b0;
                    out_dir_next     = direction_reg;
                    out_period_next  = unit_rsp.period;
                    state_next       = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            elapsed_reg     <= '0;
            step_period_reg <= sssp_pkg::RESET_PERIOD;
            direction_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
            out_step_reg    <= 1'b0;
            out_dir_reg     <= 1'b1;
            out_period_reg  <= sssp_pkg::RESET_PERIOD;
        end
        else
        begin
            state_reg       <= state_next;
            elapsed_reg     <= elapsed_next;
            step_period_reg <= step_period_next;
            direction_reg   <= direction_next;
            out_valid_reg   <= out_valid_next;
            out_step_reg    <= out_step_next;
            out_dir_reg     <= out_dir_next;
            out_period_reg  <= out_period_next;
        end
    end

    // result outputs
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.step       = out_step_reg;
    assign out_ch.dir_first  = out_dir_reg;
    assign out_ch.dir_second = !out_dir_reg;
    assign out_ch.period_us  = out_period_reg;

    // checks
    `SSSP_ASSERT_SAME(a_accept_unit_idle, clk, rst_n, in_acc, !unit_rsp.busy)
    `SSSP_ASSERT_SAME(a_ack_only_done, clk, rst_n, unit_req.ack, unit_rsp.done)
    `SSSP_ASSERT_NEXT(a_step_clears, clk, rst_n, in_acc && !in_ch.op && tick_step, elapsed_reg == '0)

endmodule
